[sv/v3alu_pkg.sv]
`timescale 1ns / 1ps

package v3alu_pkg;

  // number formats
  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int ANG_BITS     = 30;
  localparam int DW           = 32;
  localparam int ANG_W        = 19;
  localparam int OP_W         = 4;

  // operation codes
  localparam logic [OP_W-1:0] OP_ADD       = 4'd0;
  localparam logic [OP_W-1:0] OP_SUB       = 4'd1;
  localparam logic [OP_W-1:0] OP_CROSS     = 4'd2;
  localparam logic [OP_W-1:0] OP_DOT       = 4'd3;
  localparam logic [OP_W-1:0] OP_NORM      = 4'd4;
  localparam logic [OP_W-1:0] OP_NORMALIZE = 4'd5;
  localparam logic [OP_W-1:0] OP_ROT_XY    = 4'd6;
  localparam logic [OP_W-1:0] OP_ROT_XZ    = 4'd7;
  localparam logic [OP_W-1:0] OP_ROT_YZ    = 4'd8;

  // angle and cordic widths, angles in Q2.30
  localparam int ZW     = 34;
  localparam int ZPRE_W = (ANG_W + ANG_BITS - FRAC_BITS + 1 > ZW) ?
                          ANG_W + ANG_BITS - FRAC_BITS + 1 : ZW;
  localparam logic signed [ZW-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam int CW = 33;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 33'sd652032874;

  // wide intermediate width for saturation
  localparam int SATW = 2 * DW + 4;

  // pipeline depths, counted from the input register
  localparam int SQRT_STEPS = DW;
  localparam int DIV_STEPS  = FRAC_BITS + 1;
  localparam int ARITH_LAT  = 3;
  localparam int ROT_LAT    = CORDIC_STEPS + 5;
  localparam int NORM_LAT   = 3 + SQRT_STEPS + DIV_STEPS + 1;

  typedef logic [OP_W-1:0] op_t;

  typedef struct packed {
    logic signed [DW-1:0] rx;
    logic signed [DW-1:0] ry;
    logic signed [DW-1:0] rz;
    logic                 saturated;
    logic                 zero_length;
  } res_t;

  // arctangent of 2^-i in Q2.30
  function automatic logic [31:0] atan_q30(input int i);
    logic [31:0] v;
    case (i)
      0:       v = 32'h3243F6A8;
      1:       v = 32'h1DAC6705;
      2:       v = 32'h0FADBAFC;
      3:       v = 32'h07F56EA6;
      4:       v = 32'h03FEAB76;
      5:       v = 32'h01FFD55B;
      6:       v = 32'h00FFFAAA;
      7:       v = 32'h007FFF55;
      8:       v = 32'h003FFFEA;
      9:       v = 32'h001FFFFD;
      10:      v = 32'h000FFFFF;
      11:      v = 32'h0007FFFF;
      12:      v = 32'h0003FFFF;
      13:      v = 32'h0001FFFF;
      14:      v = 32'h0000FFFF;
      15:      v = 32'h00007FFF;
      16:      v = 32'h00003FFF;
      17:      v = 32'h00001FFF;
      18:      v = 32'h00000FFF;
      19:      v = 32'h000007FF;
      20:      v = 32'h000003FF;
      21:      v = 32'h000001FF;
      22:      v = 32'h000000FF;
      23:      v = 32'h0000007F;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

  // clip a wide signed value to DW bits, flag in the top bit
  function automatic logic [DW:0] sat_dw(input logic signed [SATW-1:0] v);
    logic [DW:0] r;
    if ((&v[SATW-1:DW-1]) || !(|v[SATW-1:DW-1])) begin
      r = {1'b0, v[DW-1:0]};
    end else if (v[SATW-1]) begin
      r = {1'b1, 1'b1, {(DW-1){1'b0}}};
    end else begin
      r = {1'b1, 1'b0, {(DW-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

[sv/v3alu_in_if.sv]
`timescale 1ns / 1ps

interface v3alu_in_if import v3alu_pkg::*; ();
  logic                    valid;
  logic                    ready;
  op_t                     operation;
  logic signed [DW-1:0]    ax;
  logic signed [DW-1:0]    ay;
  logic signed [DW-1:0]    az;
  logic signed [DW-1:0]    bx;
  logic signed [DW-1:0]    by;
  logic signed [DW-1:0]    bz;
  logic signed [ANG_W-1:0] angle;

  modport source (output valid, operation, ax, ay, az, bx, by, bz, angle, input ready);
  modport sink (input valid, operation, ax, ay, az, bx, by, bz, angle, output ready);
endinterface

[sv/v3alu_out_if.sv]
`timescale 1ns / 1ps

interface v3alu_out_if import v3alu_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] rx;
  logic signed [DW-1:0] ry;
  logic signed [DW-1:0] rz;
  logic                 saturated;
  logic                 zero_length;

  modport source (output valid, rx, ry, rz, saturated, zero_length, input ready);
  modport sink (input valid, rx, ry, rz, saturated, zero_length, output ready);
endinterface

[sv/v3alu_rot.sv]
`timescale 1ns / 1ps

module v3alu_rot import v3alu_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  op_t                     op,
  input  logic signed [DW-1:0]    ax,
  input  logic signed [DW-1:0]    ay,
  input  logic signed [DW-1:0]    az,
  input  logic signed [ANG_W-1:0] angle,
  output res_t                    res
);

  localparam int PW = DW + CW;

  logic signed [ZW-1:0] cz   [0:CORDIC_STEPS-1];
  logic signed [CW-1:0] cx   [1:CORDIC_STEPS];
  logic signed [CW-1:0] cy   [1:CORDIC_STEPS];
  logic                 cneg [0:CORDIC_STEPS];
  logic signed [DW-1:0] cp   [0:CORDIC_STEPS];
  logic signed [DW-1:0] cq   [0:CORDIC_STEPS];
  logic signed [DW-1:0] cpas [0:CORDIC_STEPS];
  op_t                  cop  [0:CORDIC_STEPS];

  // angle scaling, clamp to pi and fold into the half plane
  logic signed [ZPRE_W-1:0] zw;
  logic signed [ZPRE_W-1:0] pi_w;
  logic signed [ZW-1:0]     zc;
  logic signed [ZW-1:0]     zr;
  logic                     zneg;
  logic signed [DW-1:0]     sel_p, sel_q, sel_pas;

  always_comb begin
    pi_w = ZPRE_W'(PI_Q30);
    zw   = ZPRE_W'(angle) <<< (ANG_BITS - FRAC_BITS);
    if (zw > pi_w) begin
      zw = pi_w;
    end else if (zw < -pi_w) begin
      zw = -pi_w;
    end
    zc   = zw[ZW-1:0];
    zr   = zc;
    zneg = 1'b0;
    if (zc > HALF_PI_Q30) begin
      zr   = zc - PI_Q30;
      zneg = 1'b1;
    end else if (zc < -HALF_PI_Q30) begin
      zr   = zc + PI_Q30;
      zneg = 1'b1;
    end
  end

  // pick the component pair to rotate
  always_comb begin
    case (op)
      OP_ROT_XZ: begin
        sel_p = ax; sel_q = az; sel_pas = ay;
      end
      OP_ROT_YZ: begin
        sel_p = ay; sel_q = az; sel_pas = ax;
      end
      default: begin
        sel_p = ax; sel_q = ay; sel_pas = az;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cz[0]   <= zr;
      cneg[0] <= zneg;
      cp[0]   <= sel_p;
      cq[0]   <= sel_q;
      cpas[0] <= sel_pas;
      cop[0]  <= op;
    end
  end

  // one micro-rotation per stage
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    logic signed [CW-1:0] xi, yi, xn, yn;
    logic signed [ZW-1:0] zn;

    if (i == 0) begin : g_first
      assign xi = CORDIC_GAIN;
      assign yi = '0;
    end else begin : g_rest
      assign xi = cx[i];
      assign yi = cy[i];
    end

    always_comb begin
      if (!cz[i][ZW-1]) begin
        xn = xi - (yi >>> i);
        yn = yi + (xi >>> i);
        zn = cz[i] - ZW'(atan_q30(i));
      end else begin
        xn = xi + (yi >>> i);
        yn = yi - (xi >>> i);
        zn = cz[i] + ZW'(atan_q30(i));
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cx[i+1]   <= xn;
        cy[i+1]   <= yn;
        cneg[i+1] <= cneg[i];
        cp[i+1]   <= cp[i];
        cq[i+1]   <= cq[i];
        cpas[i+1] <= cpas[i];
        cop[i+1]  <= cop[i];
      end
    end

    if (i < CORDIC_STEPS - 1) begin : g_zreg
      always_ff @(posedge clk) begin
        if (en) begin
          cz[i+1] <= zn;
        end
      end
    end
  end

  // sign fix of cosine and sine
  logic signed [CW-1:0] sc_c, sc_s;
  logic signed [DW-1:0] sc_p, sc_q, sc_pas;
  op_t                  sc_op;

  always_ff @(posedge clk) begin
    if (en) begin
      sc_c   <= cneg[CORDIC_STEPS] ? -cx[CORDIC_STEPS] : cx[CORDIC_STEPS];
      sc_s   <= cneg[CORDIC_STEPS] ? -cy[CORDIC_STEPS] : cy[CORDIC_STEPS];
      sc_p   <= cp[CORDIC_STEPS];
      sc_q   <= cq[CORDIC_STEPS];
      sc_pas <= cpas[CORDIC_STEPS];
      sc_op  <= cop[CORDIC_STEPS];
    end
  end

  // four products
  logic signed [PW-1:0] m_pc, m_ps, m_qc, m_qs;
  logic signed [DW-1:0] m_pas;
  op_t                  m_op;

  always_ff @(posedge clk) begin
    if (en) begin
      m_pc  <= sc_p * sc_c;
      m_ps  <= sc_p * sc_s;
      m_qc  <= sc_q * sc_c;
      m_qs  <= sc_q * sc_s;
      m_pas <= sc_pas;
      m_op  <= sc_op;
    end
  end

  // sums
  logic signed [PW:0]   s_np, s_nq;
  logic signed [DW-1:0] s_pas;
  op_t                  s_op;

  always_ff @(posedge clk) begin
    if (en) begin
      s_np  <= (PW+1)'(m_pc) - (PW+1)'(m_qs);
      s_nq  <= (PW+1)'(m_ps) + (PW+1)'(m_qc);
      s_pas <= m_pas;
      s_op  <= m_op;
    end
  end

  // rescale, saturate and place the components
  logic [DW:0] f_p, f_q;
  res_t        f_res;

  always_comb begin
    f_p = sat_dw(SATW'(s_np >>> ANG_BITS));
    f_q = sat_dw(SATW'(s_nq >>> ANG_BITS));
    f_res.saturated   = f_p[DW] | f_q[DW];
    f_res.zero_length = 1'b0;
    case (s_op)
      OP_ROT_XZ: begin
        f_res.rx = f_p[DW-1:0]; f_res.ry = s_pas; f_res.rz = f_q[DW-1:0];
      end
      OP_ROT_YZ: begin
        f_res.rx = s_pas; f_res.ry = f_p[DW-1:0]; f_res.rz = f_q[DW-1:0];
      end
      default: begin
        f_res.rx = f_p[DW-1:0]; f_res.ry = f_q[DW-1:0]; f_res.rz = s_pas;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= f_res;
    end
  end

endmodule

[sv/v3alu_norm.sv]
`timescale 1ns / 1ps

module v3alu_norm import v3alu_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  op_t                  op,
  input  logic signed [DW-1:0] ax,
  input  logic signed [DW-1:0] ay,
  input  logic signed [DW-1:0] az,
  output res_t                 res
);

  localparam int CL = SQRT_STEPS + DIV_STEPS;

  // magnitudes and signs
  logic [2:0][DW-1:0] n1_mag;
  logic [2:0]         n1_sg;
  op_t                n1_op;

  always_ff @(posedge clk) begin
    if (en) begin
      n1_mag[0] <= ax[DW-1] ? DW'(-ax) : DW'(ax);
      n1_mag[1] <= ay[DW-1] ? DW'(-ay) : DW'(ay);
      n1_mag[2] <= az[DW-1] ? DW'(-az) : DW'(az);
      n1_sg     <= {az[DW-1], ay[DW-1], ax[DW-1]};
      n1_op     <= op;
    end
  end

  // squares
  logic [2:0][2*DW-1:0] n2_sq;
  logic [2:0][DW-1:0]   n2_mag;
  logic [2:0]           n2_sg;
  op_t                  n2_op;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        n2_sq[k] <= (2*DW)'(n1_mag[k]) * (2*DW)'(n1_mag[k]);
      end
      n2_mag <= n1_mag;
      n2_sg  <= n1_sg;
      n2_op  <= n1_op;
    end
  end

  // carried side data, index 0 is the sum stage
  logic [2*DW-1:0]    sn  [0:SQRT_STEPS-1];
  logic [2*DW-1:0]    sr  [1:SQRT_STEPS];
  logic [2:0][DW-1:0] cm  [0:SQRT_STEPS];
  logic [2:0]         csg [0:CL];
  op_t                cop [0:CL];

  // sum of squares
  always_ff @(posedge clk) begin
    if (en) begin
      sn[0]  <= n2_sq[0] + n2_sq[1] + n2_sq[2];
      cm[0]  <= n2_mag;
      csg[0] <= n2_sg;
      cop[0] <= n2_op;
    end
  end

  // integer square root, one result bit per stage
  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    logic [2*DW-1:0] ri, rn, nn, bt, tr;

    if (j == 0) begin : g_first
      assign ri = '0;
    end else begin : g_rest
      assign ri = sr[j];
    end

    assign bt = (2*DW)'(1) << (2 * (SQRT_STEPS - 1 - j));
    assign tr = ri + bt;

    always_comb begin
      if (sn[j] >= tr) begin
        nn = sn[j] - tr;
        rn = (ri >> 1) + bt;
      end else begin
        nn = sn[j];
        rn = ri >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sr[j+1]  <= rn;
        cm[j+1]  <= cm[j];
        csg[j+1] <= csg[j];
        cop[j+1] <= cop[j];
      end
    end

    if (j < SQRT_STEPS - 1) begin : g_nreg
      always_ff @(posedge clk) begin
        if (en) begin
          sn[j+1] <= nn;
        end
      end
    end
  end

  // three restoring dividers, one quotient bit per stage
  logic [DW-1:0]               dm   [1:DIV_STEPS];
  logic [2:0][DW:0]            drem [1:DIV_STEPS-1];
  logic [2:0][DIV_STEPS-1:0]   dq   [1:DIV_STEPS];

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic [DW-1:0]             mi;
    logic [2:0][DW:0]          ri, rn;
    logic [2:0][DIV_STEPS-1:0] qi, qn;

    if (j == 0) begin : g_first
      assign mi = sr[SQRT_STEPS][DW-1:0];
      assign qi = '0;
      for (genvar k = 0; k < 3; k++) begin : g_lane
        assign ri[k] = {1'b0, cm[SQRT_STEPS][k]};
      end
    end else begin : g_rest
      assign mi = dm[j];
      assign qi = dq[j];
      for (genvar k = 0; k < 3; k++) begin : g_lane
        assign ri[k] = {drem[j][k][DW-1:0], 1'b0};
      end
    end

    always_comb begin
      for (int k = 0; k < 3; k++) begin
        if (ri[k] >= {1'b0, mi}) begin
          rn[k] = ri[k] - {1'b0, mi};
          qn[k] = {qi[k][DIV_STEPS-2:0], 1'b1};
        end else begin
          rn[k] = ri[k];
          qn[k] = {qi[k][DIV_STEPS-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dm[j+1]                 <= mi;
        dq[j+1]                 <= qn;
        csg[SQRT_STEPS+j+1]     <= csg[SQRT_STEPS+j];
        cop[SQRT_STEPS+j+1]     <= cop[SQRT_STEPS+j];
      end
    end

    if (j < DIV_STEPS - 1) begin : g_rreg
      always_ff @(posedge clk) begin
        if (en) begin
          drem[j+1] <= rn;
        end
      end
    end
  end

  // final result: magnitude or signed unit vector
  logic [DW-1:0] fm;
  logic [2:0]    fsg;
  logic [DW-1:0] fq [3];
  res_t          f_res;

  always_comb begin
    fm  = dm[DIV_STEPS];
    fsg = csg[CL];
    for (int k = 0; k < 3; k++) begin
      fq[k] = fsg[k] ? DW'(-DW'(dq[DIV_STEPS][k])) : DW'(dq[DIV_STEPS][k]);
    end
    f_res = '0;
    case (cop[CL])
      OP_NORM: begin
        if (fm[DW-1]) begin
          f_res.rx        = {1'b0, {(DW-1){1'b1}}};
          f_res.saturated = 1'b1;
        end else begin
          f_res.rx = fm;
        end
      end
      OP_NORMALIZE: begin
        if (fm == '0) begin
          f_res.zero_length = 1'b1;
        end else begin
          f_res.rx = fq[0];
          f_res.ry = fq[1];
          f_res.rz = fq[2];
        end
      end
      default: begin
        f_res = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= f_res;
    end
  end

endmodule

[sv/vec3_arithmetic_unit.sv]
`timescale 1ns / 1ps
// Three-component vector unit, signed Q16.16.
// req channel: one beat carries an operation code, vectors a and b and an
// angle; rsp channel: one beat carries rx, ry, rz and the saturated and
// zero_length flags. Scalar results (dot, norm) come back in rx.
// Every operation runs through the same pipeline, so results leave in the
// order the requests came in.
// Pipeline depth is set by the square root (32 stages) and the three
// parallel dividers (17 stages) of the norm path; the CORDIC path and the
// add, cross and dot path are padded to the same depth.
// Throughput: one beat per cycle, back to back, when rsp is not stalled.
// Stall: while rsp holds a beat that is not taken, the whole pipeline and
// req.ready hold; nothing is dropped or repeated.
// Reset: rst clears all valid bits; the first request can follow the next
// cycle.

module vec3_arithmetic_unit import v3alu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  v3alu_in_if.sink    req,
  v3alu_out_if.source rsp
);

  // pipeline advance
  logic en;
  assign en        = !rsp.valid || rsp.ready;
  assign req.ready = en;

  // input register
  logic                    s0_valid;
  op_t                     s0_op;
  logic signed [DW-1:0]    s0_a [3];
  logic signed [DW-1:0]    s0_b [3];
  logic signed [ANG_W-1:0] s0_angle;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= req.valid;
    end
    if (en) begin
      s0_op    <= req.operation;
      s0_a[0]  <= req.ax;
      s0_a[1]  <= req.ay;
      s0_a[2]  <= req.az;
      s0_b[0]  <= req.bx;
      s0_b[1]  <= req.by;
      s0_b[2]  <= req.bz;
      s0_angle <= req.angle;
    end
  end

  // valid and opcode travel with the data
  logic vld [1:NORM_LAT];
  op_t  opd [1:NORM_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= NORM_LAT; k++) begin
        vld[k] <= 1'b0;
      end
    end else if (en) begin
      vld[1] <= s0_valid;
      for (int k = 2; k <= NORM_LAT; k++) begin
        vld[k] <= vld[k-1];
      end
    end
    if (en) begin
      opd[1] <= s0_op;
      for (int k = 2; k <= NORM_LAT; k++) begin
        opd[k] <= opd[k-1];
      end
    end
  end

  // add and sub, and all products
  logic signed [DW:0]     as_sum [3];
  logic [DW:0]            as_sat [3];
  res_t                   a1_as;
  logic signed [2*DW-1:0] a1_pc [3];
  logic signed [2*DW-1:0] a1_pd [3];
  logic signed [2*DW-1:0] a1_pp [3];
  op_t                    a1_op;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (s0_op == OP_SUB) begin
        as_sum[k] = (DW+1)'(s0_a[k]) - (DW+1)'(s0_b[k]);
      end else begin
        as_sum[k] = (DW+1)'(s0_a[k]) + (DW+1)'(s0_b[k]);
      end
      as_sat[k] = sat_dw(SATW'(as_sum[k]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_as.rx          <= as_sat[0][DW-1:0];
      a1_as.ry          <= as_sat[1][DW-1:0];
      a1_as.rz          <= as_sat[2][DW-1:0];
      a1_as.saturated   <= as_sat[0][DW] | as_sat[1][DW] | as_sat[2][DW];
      a1_as.zero_length <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        a1_pc[k] <= s0_a[(k+1)%3] * s0_b[(k+2)%3];
        a1_pd[k] <= s0_a[(k+2)%3] * s0_b[(k+1)%3];
        a1_pp[k] <= s0_a[k] * s0_b[k];
      end
      a1_op <= s0_op;
    end
  end

  // cross differences and dot sum
  logic signed [SATW-1:0] a2_cr [3];
  logic signed [SATW-1:0] a2_dot;
  res_t                   a2_as;
  op_t                    a2_op;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        a2_cr[k] <= SATW'(a1_pc[k]) - SATW'(a1_pd[k]);
      end
      a2_dot <= SATW'(a1_pp[0]) + SATW'(a1_pp[1]) + SATW'(a1_pp[2]);
      a2_as  <= a1_as;
      a2_op  <= a1_op;
    end
  end

  // rescale, saturate and choose
  logic [DW:0] cr_sat [3];
  logic [DW:0] dot_sat;
  res_t        a3_next;
  res_t        a3_res;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cr_sat[k] = sat_dw(a2_cr[k] >>> FRAC_BITS);
    end
    dot_sat = sat_dw(a2_dot >>> FRAC_BITS);
    case (a2_op)
      OP_CROSS: begin
        a3_next.rx          = cr_sat[0][DW-1:0];
        a3_next.ry          = cr_sat[1][DW-1:0];
        a3_next.rz          = cr_sat[2][DW-1:0];
        a3_next.saturated   = cr_sat[0][DW] | cr_sat[1][DW] | cr_sat[2][DW];
        a3_next.zero_length = 1'b0;
      end
      OP_DOT: begin
        a3_next             = '0;
        a3_next.rx          = dot_sat[DW-1:0];
        a3_next.saturated   = dot_sat[DW];
      end
      default: begin
        a3_next = a2_as;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a3_res <= a3_next;
    end
  end

  // rotation path
  res_t rot_res;

  v3alu_rot u_rot (
    .clk   (clk),
    .en    (en),
    .op    (s0_op),
    .ax    (s0_a[0]),
    .ay    (s0_a[1]),
    .az    (s0_a[2]),
    .angle (s0_angle),
    .res   (rot_res)
  );

  // norm and normalize path
  res_t norm_res;

  v3alu_norm u_norm (
    .clk (clk),
    .en  (en),
    .op  (s0_op),
    .ax  (s0_a[0]),
    .ay  (s0_a[1]),
    .az  (s0_a[2]),
    .res (norm_res)
  );

  // align the shorter paths to the norm path
  res_t ad [ARITH_LAT+1:NORM_LAT];
  res_t rd [ROT_LAT+1:NORM_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      ad[ARITH_LAT+1] <= a3_res;
      for (int k = ARITH_LAT + 2; k <= NORM_LAT; k++) begin
        ad[k] <= ad[k-1];
      end
      rd[ROT_LAT+1] <= rot_res;
      for (int k = ROT_LAT + 2; k <= NORM_LAT; k++) begin
        rd[k] <= rd[k-1];
      end
    end
  end

  // result select
  res_t fin;

  always_comb begin
    case (opd[NORM_LAT])
      OP_ADD, OP_SUB, OP_CROSS, OP_DOT: begin
        fin = ad[NORM_LAT];
      end
      OP_NORM, OP_NORMALIZE: begin
        fin = norm_res;
      end
      OP_ROT_XY, OP_ROT_XZ, OP_ROT_YZ: begin
        fin = rd[NORM_LAT];
      end
      default: begin
        fin = '0;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (en) begin
      rsp.valid <= vld[NORM_LAT];
    end
    if (en) begin
      rsp.rx          <= fin.rx;
      rsp.ry          <= fin.ry;
      rsp.rz          <= fin.rz;
      rsp.saturated   <= fin.saturated;
      rsp.zero_length <= fin.zero_length;
    end
  end

endmodule

[sim/vec3_result_check.sv]
`timescale 1ns / 1ps

module vec3_result_check import v3alu_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  v3alu_in_if   req,
  v3alu_out_if  rsp,
  output int    mismatches,
  output int    pending
);

  typedef logic signed [127:0] wide_t;

  localparam longint ATAN_Q30 [0:23] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
    64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
    64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
  };

  res_t expected_q[$];
  int   err_count = 0;

  assign mismatches = err_count;
  assign pending    = expected_q.size();

  // clip to 32 bits, raise the flag on clipping
  function automatic logic signed [DW-1:0] clip_word(input wide_t v, inout logic flag);
    if (v > wide_t'(32'sh7FFFFFFF)) begin
      flag = 1'b1;
      return 32'sh7FFFFFFF;
    end
    if (v < -wide_t'(64'sh80000000)) begin
      flag = 1'b1;
      return 32'sh80000000;
    end
    return v[DW-1:0];
  endfunction

  // integer square root, floor
  function automatic longint unsigned root_floor(input longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // cosine and sine in Q2.30 from a Q3.16 angle
  function automatic void angle_sincos(input logic signed [ANG_W-1:0] ang,
                                       output longint c, output longint s);
    longint z;
    longint x;
    longint y;
    longint nx;
    logic   flip;
    z = longint'(ang) * (longint'(1) << (ANG_BITS - FRAC_BITS));
    x = longint'(CORDIC_GAIN);
    y = 0;
    flip = 1'b0;
    if (z > longint'(PI_Q30)) z = longint'(PI_Q30);
    if (z < -longint'(PI_Q30)) z = -longint'(PI_Q30);
    if (z > longint'(HALF_PI_Q30)) begin
      z = z - longint'(PI_Q30);
      flip = 1'b1;
    end else if (z < -longint'(HALF_PI_Q30)) begin
      z = z + longint'(PI_Q30);
      flip = 1'b1;
    end
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - ATAN_Q30[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + ATAN_Q30[i];
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // rotate the pair (p, q) by the angle given as cosine and sine
  function automatic void turn_pair(input wide_t p, input wide_t q, input longint c,
                                    input longint s, output logic signed [DW-1:0] np,
                                    output logic signed [DW-1:0] nq, inout logic flag);
    np = clip_word((p * wide_t'(c) - q * wide_t'(s)) >>> ANG_BITS, flag);
    nq = clip_word((p * wide_t'(s) + q * wide_t'(c)) >>> ANG_BITS, flag);
  endfunction

  // expected result of one request beat
  function automatic res_t vector_result(input op_t op,
      input logic signed [DW-1:0] ax, input logic signed [DW-1:0] ay,
      input logic signed [DW-1:0] az, input logic signed [DW-1:0] bx,
      input logic signed [DW-1:0] by, input logic signed [DW-1:0] bz,
      input logic signed [ANG_W-1:0] ang);
    res_t r;
    wide_t a0, a1, a2, b0, b1, b2;
    longint unsigned mx, my, mz, m;
    longint c, s;
    logic sat;
    a0 = wide_t'(ax); a1 = wide_t'(ay); a2 = wide_t'(az);
    b0 = wide_t'(bx); b1 = wide_t'(by); b2 = wide_t'(bz);
    r = '0;
    sat = 1'b0;
    case (op)
      OP_ADD: begin
        r.rx = clip_word(a0 + b0, sat);
        r.ry = clip_word(a1 + b1, sat);
        r.rz = clip_word(a2 + b2, sat);
      end
      OP_SUB: begin
        r.rx = clip_word(a0 - b0, sat);
        r.ry = clip_word(a1 - b1, sat);
        r.rz = clip_word(a2 - b2, sat);
      end
      OP_CROSS: begin
        r.rx = clip_word((a1 * b2 - a2 * b1) >>> FRAC_BITS, sat);
        r.ry = clip_word((a2 * b0 - a0 * b2) >>> FRAC_BITS, sat);
        r.rz = clip_word((a0 * b1 - a1 * b0) >>> FRAC_BITS, sat);
      end
      OP_DOT: r.rx = clip_word((a0 * b0 + a1 * b1 + a2 * b2) >>> FRAC_BITS, sat);
      OP_NORM, OP_NORMALIZE: begin
        mx = (a0 < 0) ? longint'(-a0) : longint'(a0);
        my = (a1 < 0) ? longint'(-a1) : longint'(a1);
        mz = (a2 < 0) ? longint'(-a2) : longint'(a2);
        m = root_floor(mx * mx + my * my + mz * mz);
        if (op == OP_NORM) begin
          r.rx = clip_word(wide_t'({1'b0, m}), sat);
        end else if (m == 0) begin
          r.zero_length = 1'b1;
        end else begin
          r.rx = clip_word((a0 < 0) ? -wide_t'({1'b0, (mx << FRAC_BITS) / m})
                                    : wide_t'({1'b0, (mx << FRAC_BITS) / m}), sat);
          r.ry = clip_word((a1 < 0) ? -wide_t'({1'b0, (my << FRAC_BITS) / m})
                                    : wide_t'({1'b0, (my << FRAC_BITS) / m}), sat);
          r.rz = clip_word((a2 < 0) ? -wide_t'({1'b0, (mz << FRAC_BITS) / m})
                                    : wide_t'({1'b0, (mz << FRAC_BITS) / m}), sat);
        end
      end
      OP_ROT_XY: begin
        angle_sincos(ang, c, s);
        turn_pair(a0, a1, c, s, r.rx, r.ry, sat);
        r.rz = az;
      end
      OP_ROT_XZ: begin
        angle_sincos(ang, c, s);
        turn_pair(a0, a2, c, s, r.rx, r.rz, sat);
        r.ry = ay;
      end
      OP_ROT_YZ: begin
        angle_sincos(ang, c, s);
        turn_pair(a1, a2, c, s, r.ry, r.rz, sat);
        r.rx = ax;
      end
      default: ;
    endcase
    r.saturated = sat;
    return r;
  endfunction

  task automatic report(input string field, input logic [DW-1:0] got,
                        input logic [DW-1:0] want);
    $display("%0t: %s mismatch, got %h expected %h", $realtime, field, got, want);
    err_count++;
  endtask

  // predict on each request beat, compare on each result beat
  always @(posedge clk) begin
    res_t e;
    if (!rst) begin
      if (req.valid && req.ready)
        expected_q.push_back(vector_result(req.operation, req.ax, req.ay, req.az,
                                           req.bx, req.by, req.bz, req.angle));
      if (rsp.valid && rsp.ready) begin
        if (expected_q.size() == 0) begin
          report("unexpected beat", rsp.rx, '0);
        end else begin
          e = expected_q.pop_front();
          if (rsp.rx !== e.rx) report("rx", rsp.rx, e.rx);
          if (rsp.ry !== e.ry) report("ry", rsp.ry, e.ry);
          if (rsp.rz !== e.rz) report("rz", rsp.rz, e.rz);
          if (rsp.saturated !== e.saturated)
            report("saturated", rsp.saturated, e.saturated);
          if (rsp.zero_length !== e.zero_length)
            report("zero_length", rsp.zero_length, e.zero_length);
        end
      end
    end
  end

endmodule

[sim/tb_vec3_arithmetic_unit.sv]
`timescale 1ns / 1ps

module tb_vec3_arithmetic_unit;
  import v3alu_pkg::*;

  typedef struct packed {
    op_t                     op;
    logic signed [DW-1:0]    ax, ay, az, bx, by, bz;
    logic signed [ANG_W-1:0] angle;
  } vec_req_t;

  localparam int RANDOM_BEATS = 1630;
  localparam int CYCLE_LIMIT  = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   mismatches;
  int   pending;
  int   cycles = 0;
  int   burst_left = 0;
  logic long_hold = 1'b0;

  v3alu_in_if  req_ch ();
  v3alu_out_if rsp_ch ();

  vec3_arithmetic_unit dut (.clk(clk), .rst(rst), .req(req_ch), .rsp(rsp_ch));

  vec3_result_check u_check (
    .clk(clk), .rst(rst), .req(req_ch), .rsp(rsp_ch),
    .mismatches(mismatches), .pending(pending)
  );

  always #1 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic vec_req_t mk(input op_t op, input logic [DW-1:0] ax,
      input logic [DW-1:0] ay, input logic [DW-1:0] az, input logic [DW-1:0] bx,
      input logic [DW-1:0] by, input logic [DW-1:0] bz, input logic [ANG_W-1:0] ang);
    vec_req_t it;
    it.op = op; it.ax = ax; it.ay = ay; it.az = az;
    it.bx = bx; it.by = by; it.bz = bz; it.angle = ang;
    return it;
  endfunction

  // component mix: full range, extremes, small, medium, whole numbers, zero
  function automatic logic [DW-1:0] pick_comp();
    case ($urandom_range(0, 7))
      0, 1:    return $urandom;
      2:       return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      3, 4:    return $urandom_range(0, 1) ? $urandom_range(0, 1 << 20)
                                          : -$urandom_range(0, 1 << 20);
      5:       return $signed($urandom_range(0, 65535) - 32768) <<< FRAC_BITS;
      6:       return 32'h0;
      default: return $urandom_range(0, 1) ? $urandom_range(0, 1 << 26)
                                          : -$urandom_range(0, 1 << 26);
    endcase
  endfunction

  function automatic logic [ANG_W-1:0] pick_angle();
    case ($urandom_range(0, 9))
      0:       return ANG_W'($urandom);
      1:       return $urandom_range(0, 1) ? 19'h3FFFF : 19'h40000;
      2:       return $urandom_range(0, 1) ? 19'sd205887 : -19'sd205887;
      default: return ANG_W'($urandom_range(0, 411774) - 205887);
    endcase
  endfunction

  function automatic vec_req_t pick_beat();
    vec_req_t it;
    it = mk(op_t'($urandom_range(0, 19) == 0 ? $urandom_range(9, 15)
                                             : $urandom_range(0, 8)),
            pick_comp(), pick_comp(), pick_comp(), pick_comp(), pick_comp(),
            pick_comp(), pick_angle());
    if ((it.op == OP_NORMALIZE || it.op == OP_NORM) && $urandom_range(0, 7) == 0)
      {it.ax, it.ay, it.az} = '0;
    return it;
  endfunction

  // one request beat, entered and left at a rising edge; gaps between bursts
  task automatic put_beat(input vec_req_t it);
    int gap;
    req_ch.valid     <= 1'b1;
    req_ch.operation <= it.op;
    req_ch.ax <= it.ax; req_ch.ay <= it.ay; req_ch.az <= it.az;
    req_ch.bx <= it.bx; req_ch.by <= it.by; req_ch.bz <= it.bz;
    req_ch.angle <= it.angle;
    @(negedge clk);
    while (!req_ch.ready) @(negedge clk);
    @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // pause the sender until every expected result is back
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // receiver: always-ready stretches, random stalls, one long hold-off on request
  initial begin
    int mode;
    int left;
    int duty;
    int held;
    rsp_ch.ready <= 1'b0;
    left = 0;
    mode = 0;
    duty = 50;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        rsp_ch.ready <= 1'b0;
        held = 0;
        while (held < 300) begin
          @(posedge clk);
          held++;
        end
        long_hold = 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 2);
          duty = $urandom_range(10, 90);
          left = $urandom_range(5, 120);
        end
        left--;
        rsp_ch.ready <= (mode == 0) ? 1'b1 : ($urandom_range(0, 99) < duty);
      end
    end
  end

  // stimulus and verdict
  initial begin
    vec_req_t directed[$];
    int limit;
    req_ch.valid <= 1'b0;
    req_ch.operation <= OP_ADD;
    req_ch.ax <= '0; req_ch.ay <= '0; req_ch.az <= '0;
    req_ch.bx <= '0; req_ch.by <= '0; req_ch.bz <= '0;
    req_ch.angle <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // extremes, every operation, zero normalize, clamped angles, unknown codes
    directed.push_back(mk(OP_ADD, 32'h7FFFFFFF, 32'h80000000, 32'h10000,
                          32'h1, 32'hFFFFFFFF, 32'h20000, '0));
    directed.push_back(mk(OP_SUB, 32'h80000000, 32'h7FFFFFFF, 32'h0,
                          32'h1, 32'hFFFFFFFF, 32'h0, '0));
    directed.push_back(mk(OP_CROSS, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
                          32'h80000000, 32'h7FFFFFFF, 32'h80000000, '0));
    directed.push_back(mk(OP_CROSS, 32'h10000, 32'h0, 32'h0, 32'h0, 32'h10000, 32'h0, '0));
    directed.push_back(mk(OP_DOT, 32'h80000000, 32'h80000000, 32'h80000000,
                          32'h80000000, 32'h80000000, 32'h80000000, '0));
    directed.push_back(mk(OP_DOT, 32'hFFFFFFFF, 32'h3, 32'hFFFFFFFD,
                          32'h1, 32'h1, 32'h1, '0));
    directed.push_back(mk(OP_NORM, 32'h80000000, 32'h80000000, 32'h80000000, '0, '0, '0, '0));
    directed.push_back(mk(OP_NORM, 32'h30000, 32'h40000, 32'h0, '0, '0, '0, '0));
    directed.push_back(mk(OP_NORMALIZE, 32'h0, 32'h0, 32'h0, '1, '1, '1, '1));
    directed.push_back(mk(OP_NORMALIZE, 32'h80000000, 32'h1, 32'h7FFFFFFF, '0, '0, '0, '0));
    directed.push_back(mk(OP_NORMALIZE, 32'h0, 32'h0, 32'hFFFFFFFF, '0, '0, '0, '0));
    directed.push_back(mk(OP_ROT_XY, 32'h10000, 32'h0, 32'h5, '0, '0, '0, 19'sd102944));
    directed.push_back(mk(OP_ROT_XY, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h0, '0, '0, '0,
                          19'sd51472));
    directed.push_back(mk(OP_ROT_XZ, 32'h10000, 32'h7, 32'h10000, '0, '0, '0, 19'h3FFFF));
    directed.push_back(mk(OP_ROT_XZ, 32'h80000000, 32'h0, 32'h80000000, '0, '0, '0,
                          19'h40000));
    directed.push_back(mk(OP_ROT_YZ, 32'h9, 32'h10000, 32'hFFFF0000, '0, '0, '0,
                          19'sd205887));
    directed.push_back(mk(OP_ROT_YZ, 32'h0, 32'h12345, 32'h54321, '0, '0, '0,
                          -19'sd205887));
    directed.push_back(mk(OP_ROT_YZ, 32'h0, 32'h12345, 32'h54321, '0, '0, '0,
                          -19'sd120000));
    directed.push_back(mk(OP_ROT_XY, 32'hFFFFFFFF, 32'h1, 32'h0, '0, '0, '0, '0));
    directed.push_back(mk(4'd9, '1, '1, '1, '1, '1, '1, '1));
    directed.push_back(mk(4'd15, 32'h7FFFFFFF, '0, '0, '0, '0, '0, '0));
    foreach (directed[i]) put_beat(directed[i]);
    drain();

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n == 500) long_hold = 1'b1;
      if (n == 1100) drain();
      put_beat(pick_beat());
    end
    req_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    limit = 0;
    while (limit < 2 * NORM_LAT + 20) begin
      @(posedge clk);
      limit++;
    end
    if (mismatches == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
